>>> hdl/thci_pkg.sv
package thci_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = 9;   // one-based entry index, 0..TABLE_DEPTH
   localparam int SRCH_W      = 10;  // search bounds, reach past the table end
   localparam int ADDR_W      = 8;   // zero-based memory address
   localparam int DATA_W      = 32;  // Q16.16 value
   localparam int MIN_SIZE    = 4;   // four-point window

   // wide arithmetic
   localparam int LIMB_W = 32;
   localparam int NUM_W  = 128;      // |y| times three differences
   localparam int DEN_W  = 96;       // three differences
   localparam int ACC_W  = 130;      // sum of four signed quotients
   localparam int NUM_LIMBS = NUM_W / LIMB_W;
   localparam int DEN_LIMBS = DEN_W / LIMB_W;

   // command codes on the request channel
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // saturation limits
   localparam logic [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // controller to datapath
   typedef struct packed {
      logic              wr_en;
      logic              qry_load;
      logic              hold_load;
      logic              term_load;
      logic              op_num;
      logic              op_den;
      logic              mul_num;
      logic              mul_den;
      logic              div_init;
      logic              div_step;
      logic              acc_clear;
      logic              acc_add;
      logic              out_load;
      logic              degen;
      logic [ADDR_W-1:0] rd_addr;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ge;          // query x >= read x
      logic gt;          // query x >  read x
      logic rd_gt_hold;  // read x > held x (table direction)
      logic den_zero;
   } dp_stat_type;

endpackage

>>> hdl/thci_datapath.sv
module thci_datapath (
   input  logic                               clock,
   input  logic [thci_pkg::IDX_W-1:0]         req_entry_index,
   input  logic signed [thci_pkg::DATA_W-1:0] req_x_value,
   input  logic signed [thci_pkg::DATA_W-1:0] req_y_value,
   input  thci_pkg::dp_cmd_type               cmd,
   output thci_pkg::dp_stat_type              stat,
   output logic [thci_pkg::DATA_W-1:0]        rsp_y_result,
   output logic                               rsp_saturated
);
   import thci_pkg::*;

   logic [DATA_W-1:0] mem_x [TABLE_DEPTH];
   logic [DATA_W-1:0] mem_y [TABLE_DEPTH];

   logic signed [DATA_W-1:0] rdx_ff, rdy_ff;
   logic signed [DATA_W-1:0] xq_ff, hold_ff, xi_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DEN_W-1:0]         den_ff, rem_ff;
   logic [LIMB_W-1:0]        op_ff, carry_ff;
   logic                     nsign_ff, dsign_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [DATA_W-1:0]        yres_ff;
   logic                     sat_ff;

   logic [ADDR_W-1:0]        waddr;
   logic signed [DATA_W:0]   dnum, dden, dsel;
   logic [DATA_W:0]          dmag, yext, ymag;
   logic [LIMB_W-1:0]        mul_a;
   logic [2*LIMB_W-1:0]      mul_t;
   logic [DEN_W:0]           rem2, rem_sub;
   logic                     rem_ge;
   logic [ACC_W-1:0]         qext, addend;
   logic                     fits;

   // table write and registered read
   assign waddr = ADDR_W'(req_entry_index - IDX_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_x[waddr] <= req_x_value;
         mem_y[waddr] <= req_y_value;
      end
      rdx_ff <= mem_x[cmd.rd_addr];
      rdy_ff <= mem_y[cmd.rd_addr];
   end

   // compares for the search
   assign stat.ge         = xq_ff >= rdx_ff;
   assign stat.gt         = xq_ff > rdx_ff;
   assign stat.rd_gt_hold = rdx_ff > hold_ff;
   assign stat.den_zero   = (den_ff == '0);

   // exact differences and magnitudes
   assign dnum = {xq_ff[DATA_W-1], xq_ff} - {rdx_ff[DATA_W-1], rdx_ff};
   assign dden = {xi_ff[DATA_W-1], xi_ff} - {rdx_ff[DATA_W-1], rdx_ff};
   assign dsel = cmd.op_den ? dden : dnum;
   assign dmag = dsel[DATA_W] ? (~dsel + (DATA_W+1)'(1)) : dsel;
   assign yext = {rdy_ff[DATA_W-1], rdy_ff};
   assign ymag = rdy_ff[DATA_W-1] ? (~yext + (DATA_W+1)'(1)) : yext;

   // one limb product per cycle
   assign mul_a = cmd.mul_den ? den_ff[LIMB_W-1:0] : num_ff[LIMB_W-1:0];
   assign mul_t = mul_a * op_ff + {{LIMB_W{1'b0}}, carry_ff};

   // restoring division, one quotient bit per cycle
   assign rem2    = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge  = rem2 >= {1'b0, den_ff};
   assign rem_sub = rem2 - {1'b0, den_ff};

   // signed quotient into the sum
   assign qext   = {{(ACC_W-NUM_W){1'b0}}, num_ff};
   assign addend = (nsign_ff ^ dsign_ff) ? (~qext + ACC_W'(1)) : qext;
   assign fits   = (&acc_ff[ACC_W-1:DATA_W-1]) | ~(|acc_ff[ACC_W-1:DATA_W-1]);

   always_ff @(posedge clock) begin
      if (cmd.qry_load) xq_ff <= req_x_value;
      if (cmd.hold_load) hold_ff <= rdx_ff;
      // start a term from the window entry
      if (cmd.term_load) begin
         xi_ff    <= rdx_ff;
         num_ff   <= {{(NUM_W-DATA_W){1'b0}}, ymag[DATA_W-1:0]};
         nsign_ff <= rdy_ff[DATA_W-1];
         den_ff   <= DEN_W'(1);
         dsign_ff <= 1'b0;
      end
      // take the next factor
      if (cmd.op_num || cmd.op_den) begin
         op_ff    <= dmag[DATA_W-1:0];
         carry_ff <= '0;
         if (cmd.op_num) nsign_ff <= nsign_ff ^ dsel[DATA_W];
         else dsign_ff <= dsign_ff ^ dsel[DATA_W];
      end
      // rotate limbs through the multiplier
      if (cmd.mul_num) begin
         num_ff   <= {mul_t[LIMB_W-1:0], num_ff[NUM_W-1:LIMB_W]};
         carry_ff <= mul_t[2*LIMB_W-1:LIMB_W];
      end
      if (cmd.mul_den) begin
         den_ff   <= {mul_t[LIMB_W-1:0], den_ff[DEN_W-1:LIMB_W]};
         carry_ff <= mul_t[2*LIMB_W-1:LIMB_W];
      end
      if (cmd.div_init) rem_ff <= '0;
      if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], rem_ge};
      end
      if (cmd.acc_clear) acc_ff <= '0;
      if (cmd.acc_add) acc_ff <= acc_ff + $signed(addend);
      // saturate into the result register; a degenerate window gives zero, flagged saturated
      if (cmd.out_load) begin
         if (cmd.degen) begin
            yres_ff <= '0;
            sat_ff  <= 1'b1;
         end else if (fits) begin
            yres_ff <= acc_ff[DATA_W-1:0];
            sat_ff  <= 1'b0;
         end else begin
            yres_ff <= acc_ff[ACC_W-1] ? Y_MIN : Y_MAX;
            sat_ff  <= 1'b1;
         end
      end
   end

   assign rsp_y_result  = yres_ff;
   assign rsp_saturated = sat_ff;

endmodule

>>> hdl/thci_control.sv
module thci_control (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_cmd,
   input  logic [thci_pkg::IDX_W-1:0] req_entry_index,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [thci_pkg::IDX_W-1:0] csr_data,
   input  thci_pkg::dp_stat_type      stat,
   output thci_pkg::dp_cmd_type       cmd,
   output logic                       rsp_strobe,
   output logic [thci_pkg::IDX_W-1:0] rsp_bracket_index
);
   import thci_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RD1   = 5'd1;
   localparam logic [4:0] S_RDN   = 5'd2;
   localparam logic [4:0] S_ASC   = 5'd3;
   localparam logic [4:0] S_H0    = 5'd4;
   localparam logic [4:0] S_UP    = 5'd5;
   localparam logic [4:0] S_DN    = 5'd6;
   localparam logic [4:0] S_BIS   = 5'd7;
   localparam logic [4:0] S_BM    = 5'd8;
   localparam logic [4:0] S_WIN   = 5'd9;
   localparam logic [4:0] S_TRD   = 5'd10;
   localparam logic [4:0] S_TLD   = 5'd11;
   localparam logic [4:0] S_MRD   = 5'd12;
   localparam logic [4:0] S_MLN   = 5'd13;
   localparam logic [4:0] S_MULN  = 5'd14;
   localparam logic [4:0] S_MLD   = 5'd15;
   localparam logic [4:0] S_MULD  = 5'd16;
   localparam logic [4:0] S_NEXTM = 5'd17;
   localparam logic [4:0] S_DCHK  = 5'd18;
   localparam logic [4:0] S_DIV   = 5'd19;
   localparam logic [4:0] S_ACC   = 5'd20;
   localparam logic [4:0] S_OUT   = 5'd21;

   localparam logic [6:0] DIV_LAST = 7'(NUM_W - 1);
   localparam logic [1:0] NUM_LAST = 2'(NUM_LIMBS - 1);
   localparam logic [1:0] DEN_LAST = 2'(DEN_LIMBS - 1);
   localparam logic [1:0] LAST_PT  = 2'(MIN_SIZE - 1);

   logic [4:0]        state_ff, state_in;
   logic [IDX_W-1:0]  size_ff, size_in;
   logic [SRCH_W-1:0] jlo_ff, jlo_in, jhi_ff, jhi_in, inc_ff, inc_in;
   logic [IDX_W-1:0]  jm_ff, jm_in, j_ff, j_in, last_ff, last_in, k_ff, k_in;
   logic              asc_ff, asc_in, degen_ff, degen_in, strobe_ff, strobe_in;
   logic [1:0]        i_ff, i_in, m_ff, m_in, limb_ff, limb_in;
   logic [6:0]        cnt_ff, cnt_in;

   logic [IDX_W-1:0]  n, km1, klim;
   logic [SRCH_W-1:0] n10, inc2, probe, up_t;
   logic [SRCH_W:0]   mid_sum;
   logic              accept;

   // clamp the configured size to the legal range
   always_comb begin
      if (size_ff < IDX_W'(MIN_SIZE)) n = IDX_W'(MIN_SIZE);
      else if (size_ff > IDX_W'(TABLE_DEPTH)) n = IDX_W'(TABLE_DEPTH);
      else n = size_ff;
   end

   assign n10       = {1'b0, n};
   assign inc2      = inc_ff << 1;
   assign up_t      = jhi_ff + inc2;
   assign mid_sum   = {1'b0, jhi_ff} + {1'b0, jlo_ff};
   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign km1       = (j_ff <= IDX_W'(1)) ? IDX_W'(1) : j_ff - IDX_W'(1);
   assign klim      = n - IDX_W'(3);

   always_comb begin
      state_in  = state_ff;
      size_in   = size_ff;
      jlo_in    = jlo_ff;
      jhi_in    = jhi_ff;
      inc_in    = inc_ff;
      jm_in     = jm_ff;
      j_in      = j_ff;
      last_in   = last_ff;
      k_in      = k_ff;
      asc_in    = asc_ff;
      degen_in  = degen_ff;
      strobe_in = 1'b0;
      i_in      = i_ff;
      m_in      = m_ff;
      limb_in   = limb_ff;
      cnt_in    = cnt_ff;
      probe     = SRCH_W'(1);
      cmd       = '0;

      if (csr_valid && csr_ready) size_in = csr_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_QUERY) begin
                  cmd.qry_load = 1'b1;
                  state_in     = S_RD1;
               end else begin
                  cmd.wr_en = (req_entry_index != '0) &&
                              (req_entry_index <= IDX_W'(TABLE_DEPTH));
               end
            end
         end
         S_RD1: begin
            probe    = SRCH_W'(1);
            state_in = S_RDN;
         end
         S_RDN: begin
            cmd.hold_load = 1'b1;
            probe         = n10;
            state_in      = S_ASC;
         end
         // direction, then start from the kept index, or bisect the whole table if it is out of range
         S_ASC: begin
            asc_in = stat.rd_gt_hold;
            if (last_ff == '0 || last_ff > n) begin
               jlo_in   = '0;
               jhi_in   = n10 + SRCH_W'(1);
               state_in = S_BIS;
            end else begin
               jlo_in   = {1'b0, last_ff};
               probe    = {1'b0, last_ff};
               state_in = S_H0;
            end
         end
         S_H0: begin
            if (stat.ge == asc_ff) begin
               if (jlo_ff == n10) begin
                  j_in     = n;
                  state_in = S_WIN;
               end else begin
                  inc_in   = SRCH_W'(1);
                  jhi_in   = jlo_ff + SRCH_W'(1);
                  probe    = jlo_ff + SRCH_W'(1);
                  state_in = S_UP;
               end
            end else if (jlo_ff == SRCH_W'(1)) begin
               j_in     = '0;
               state_in = S_WIN;
            end else begin
               inc_in   = SRCH_W'(1);
               jhi_in   = jlo_ff;
               jlo_in   = jlo_ff - SRCH_W'(1);
               probe    = jlo_ff - SRCH_W'(1);
               state_in = S_DN;
            end
         end
         // gallop upward
         S_UP: begin
            if (stat.ge == asc_ff) begin
               jlo_in = jhi_ff;
               inc_in = inc2;
               if (up_t > n10) begin
                  jhi_in   = n10 + SRCH_W'(1);
                  state_in = S_BIS;
               end else begin
                  jhi_in = up_t;
                  probe  = up_t;
               end
            end else begin
               state_in = S_BIS;
            end
         end
         // gallop downward
         S_DN: begin
            if (!stat.ge == asc_ff) begin
               jhi_in = jlo_ff;
               inc_in = inc2;
               if (inc2 >= jlo_ff) begin
                  jlo_in   = '0;
                  state_in = S_BIS;
               end else begin
                  jlo_in = jlo_ff - inc2;
                  probe  = jlo_ff - inc2;
               end
            end else begin
               state_in = S_BIS;
            end
         end
         // bisect the bracket
         S_BIS: begin
            if (jhi_ff - jlo_ff > SRCH_W'(1)) begin
               jm_in    = mid_sum[IDX_W:1];
               probe    = {1'b0, mid_sum[IDX_W:1]};
               state_in = S_BM;
            end else begin
               j_in     = jlo_ff[IDX_W-1:0];
               state_in = S_WIN;
            end
         end
         S_BM: begin
            if (stat.gt == asc_ff) jlo_in = {1'b0, jm_ff};
            else jhi_in = {1'b0, jm_ff};
            state_in = S_BIS;
         end
         // place the four-point window
         S_WIN: begin
            last_in       = j_ff;
            k_in          = (km1 > klim) ? klim : km1;
            cmd.acc_clear = 1'b1;
            degen_in      = 1'b0;
            i_in          = '0;
            state_in      = S_TRD;
         end
         S_TRD: begin
            probe    = {1'b0, k_ff} + SRCH_W'(i_ff);
            state_in = S_TLD;
         end
         S_TLD: begin
            cmd.term_load = 1'b1;
            m_in          = '0;
            state_in      = S_MRD;
         end
         S_MRD: begin
            probe = {1'b0, k_ff} + SRCH_W'(m_ff);
            if (m_ff == i_ff) state_in = S_NEXTM;
            else state_in = S_MLN;
         end
         S_MLN: begin
            probe      = {1'b0, k_ff} + SRCH_W'(m_ff);
            cmd.op_num = 1'b1;
            limb_in    = '0;
            state_in   = S_MULN;
         end
         S_MULN: begin
            probe       = {1'b0, k_ff} + SRCH_W'(m_ff);
            cmd.mul_num = 1'b1;
            limb_in     = limb_ff + 2'd1;
            if (limb_ff == NUM_LAST) state_in = S_MLD;
         end
         S_MLD: begin
            cmd.op_den = 1'b1;
            limb_in    = '0;
            state_in   = S_MULD;
         end
         S_MULD: begin
            cmd.mul_den = 1'b1;
            limb_in     = limb_ff + 2'd1;
            if (limb_ff == DEN_LAST) state_in = S_NEXTM;
         end
         S_NEXTM: begin
            m_in = m_ff + 2'd1;
            if (m_ff == LAST_PT) state_in = S_DCHK;
            else state_in = S_MRD;
         end
         S_DCHK: begin
            if (stat.den_zero) begin
               degen_in = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_add = 1'b1;
            i_in        = i_ff + 2'd1;
            if (i_ff == LAST_PT) state_in = S_OUT;
            else state_in = S_TRD;
         end
         S_OUT: begin
            cmd.out_load = 1'b1;
            cmd.degen    = degen_ff;
            strobe_in    = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      cmd.rd_addr = ADDR_W'(probe - SRCH_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         size_ff   <= IDX_W'(MIN_SIZE);
         last_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         size_ff   <= size_in;
         last_ff   <= last_in;
         strobe_ff <= strobe_in;
      end
      jlo_ff   <= jlo_in;
      jhi_ff   <= jhi_in;
      inc_ff   <= inc_in;
      jm_ff    <= jm_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      asc_ff   <= asc_in;
      degen_ff <= degen_in;
      i_ff     <= i_in;
      m_ff     <= m_in;
      limb_ff  <= limb_in;
      cnt_ff   <= cnt_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_bracket_index = j_ff;

endmodule

>>> hdl/table_hunt_cubic_interpolator.sv
// channel   direction  handshake                 payload
// request   in         start high, busy low      req_cmd, req_entry_index, req_x_value,
//                                                req_y_value
// result    out        rsp_strobe, one cycle     rsp_y_result, rsp_bracket_index,
//                                                rsp_saturated
// csr       in         csr_valid and csr_ready   csr_data (table_size)
//
// A load beat writes the table in the cycle it is taken and leaves busy low.
// A query runs a search and then four terms; the bit-serial divider, which forms
// a 128-bit quotient for each term, takes most of the time.
// Reset clears the controller, the kept index and the size (4); table contents
// are undefined until loaded. The result receiver cannot stall: rsp_strobe is
// high for one cycle, and busy is low again in that same cycle.
module table_hunt_cubic_interpolator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [thci_pkg::IDX_W-1:0]         req_entry_index,
   input  logic signed [thci_pkg::DATA_W-1:0] req_x_value,
   input  logic signed [thci_pkg::DATA_W-1:0] req_y_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [thci_pkg::IDX_W-1:0]         csr_data,
   output logic                               rsp_strobe,
   output logic signed [thci_pkg::DATA_W-1:0] rsp_y_result,
   output logic [thci_pkg::IDX_W-1:0]         rsp_bracket_index,
   output logic                               rsp_saturated
);
   import thci_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   thci_control u_control (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_entry_index   (req_entry_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .stat              (stat),
      .cmd               (cmd),
      .rsp_strobe        (rsp_strobe),
      .rsp_bracket_index (rsp_bracket_index)
   );

   thci_datapath u_datapath (
      .clock           (clock),
      .req_entry_index (req_entry_index),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_y_result    (rsp_y_result),
      .rsp_saturated   (rsp_saturated)
   );

`ifndef SYNTHESIS
   // a result beat only closes a query
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a query in flight");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_bracket_index <= IDX_W'(TABLE_DEPTH)))
      else $error("bracket index past the table");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (rsp_y_result == Y_MAX || rsp_y_result == Y_MIN || rsp_y_result == '0))
      else $error("saturated result not at a limit");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beat longer than one cycle");
`endif

endmodule
